FILE: hw/rtl/tcd_pkg.sv
// Shared constants and types for the capacitive touch detector.
// Used by every module of the block; depends on nothing else.

package tcd_pkg;

  localparam int CHANNELS      = 10;
  localparam int CALIB_SAMPLES = 16;   // power of two, so the mean is a shift

  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD_W    = 16;
  localparam int SUM_W   = 22;
  localparam int SEEN_W  = 7;
  localparam int THR_W   = 10;
  localparam int PROD_W  = 2 * RD_W;

  localparam logic [THR_W-1:0] THR_RESET = 10'd82;
  localparam logic [RD_W-1:0]  ONSET_MAX = 16'hFFFF;

  localparam logic FUNC_CALIB   = 1'b0;
  localparam logic FUNC_MEASURE = 1'b1;

  typedef struct packed {
    logic [RD_W-1:0]   base;
    logic [SUM_W-1:0]  sum;
    logic [SEEN_W-1:0] seen;
    logic [RD_W-1:0]   low;
    logic [RD_W-1:0]   high;
    logic              flag;
    logic [RD_W-1:0]   onset;
  } chan_state_t;

endpackage

FILE: hw/rtl/tcd_mul_unit.sv
// Shared 16x16 unsigned multiplier with a product register.
// Depends on tcd_pkg for the operand and product widths.

module tcd_mul_unit (
  input  logic                       clk,
  input  logic                       load,
  input  logic [tcd_pkg::RD_W-1:0]   op_a,
  input  logic [tcd_pkg::RD_W-1:0]   op_b,
  output logic [tcd_pkg::PROD_W-1:0] prod,
  output logic [tcd_pkg::PROD_W-1:0] prod_r
);
  import tcd_pkg::*;

  logic [PROD_W-1:0] prod_nxt;

  assign prod     = PROD_W'(op_a) * PROD_W'(op_b);
  assign prod_nxt = load ? prod : prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: hw/rtl/tcd_chan_bank.sv
// Per-channel state registers with one shared read/write address.
// Depends on tcd_pkg for the channel count and the state record type.

module tcd_chan_bank (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tcd_pkg::CH_AW-1:0] addr,
  input  logic                      wr_en,
  input  tcd_pkg::chan_state_t      wr_data,
  output tcd_pkg::chan_state_t      rd_data
);
  import tcd_pkg::*;

  chan_state_t bank_r [CHANNELS];

  assign rd_data = bank_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        bank_r[i] <= '0;
      end
    end else if (wr_en) begin
      bank_r[addr] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/capacitive_touch_detector.sv
// Top level of the capacitive touch detector: sequencer, update and search.
// Depends on tcd_pkg, tcd_mul_unit and tcd_chan_bank.
//
// Usage: drive in_func, in_channel_index and in_reading with start high; the
// item is taken at a clock edge where start is high and busy is low. Busy
// then stays high until the result appears. A calibration sample (func 0)
// accumulates into the channel's average; a measure sample (func 1) updates
// the marks and the touch flag. Each item gives exactly one result, shown on
// the out_ ports for one cycle with out_valid high; the receiver cannot
// stall, so it must take the result in that cycle.
// Sequence: for a valid channel, one threshold multiply (THR) and one update
// step (UPD), then a span step and a compare step on the multiplier per
// channel (SPAN, CMP) for the best-channel search over all 10 channels; a
// bad channel goes straight to the search. A new item can be taken in the
// cycle the result shows, not before; items never overlap.
// The threshold register is written through cfg_valid/cfg_ready (always
// ready) and must only be changed while busy is low.
// Reset (synchronous, rst_n low) clears all channel state and sets the
// threshold to 82/1024.

module capacitive_touch_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [3:0]                  in_channel_index,
  input  logic [15:0]                 in_reading,
  output logic                        out_valid,
  output logic                        out_is_touched,
  output logic                        out_rising_edge,
  output logic [15:0]                 out_hit_total,
  output logic [15:0]                 out_lowest_seen,
  output logic [15:0]                 out_highest_seen,
  output logic [15:0]                 out_baseline_out,
  output logic                        out_calib_done,
  output logic [3:0]                  out_best_channel,
  output logic                        out_best_found,
  output logic                        out_bad_channel,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcd_pkg::THR_W-1:0]   cfg_touch_threshold
);
  import tcd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_THR  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_SPAN = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              func_r;
  logic [CH_AW-1:0]  ch_r;
  logic [RD_W-1:0]   reading_r;
  logic [CH_AW-1:0]  idx_r;

  logic              have_r;
  logic [CH_AW-1:0]  best_r;
  logic [RD_W-1:0]   best_hits_r;
  logic [RD_W-1:0]   best_num_r;
  logic [RD_W-1:0]   best_den_r;

  logic              out_valid_r;
  logic              is_touched_r, rising_r, calib_done_r, bad_r, best_found_r;
  logic [RD_W-1:0]   hit_total_r, lowest_r, highest_r, baseline_r;
  logic [3:0]        best_channel_r;

  logic              accept;
  logic              bad_in;
  logic              searching;
  logic              last_idx;

  logic [CH_AW-1:0]  bank_addr;
  logic              bank_we;
  chan_state_t       rd, wr;

  logic [RD_W-1:0]   mul_a, mul_b;
  logic              mul_load;
  logic [PROD_W-1:0] prod, prod_r;

  logic [RD_W-1:0]   diff;
  logic              now_touched;
  logic              rise;
  logic              done;
  logic [SUM_W-1:0]  sum_new;
  logic [SEEN_W-1:0] seen_new;
  logic [RD_W-1:0]   base_new;

  logic [RD_W-1:0]   below, above, span_num, span_den;
  logic              take;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign bad_in    = ({1'b0, in_channel_index} >= 5'(CHANNELS));
  assign searching = (state_r == ST_SPAN) || (state_r == ST_CMP);
  assign last_idx  = (idx_r == CH_AW'(CHANNELS - 1));
  assign bank_addr = searching ? idx_r : ch_r;

  tcd_chan_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (bank_addr),
    .wr_en   (bank_we),
    .wr_data (wr),
    .rd_data (rd)
  );

  // Relative span of the channel under search, as num/den.
  always_comb begin
    below = (rd.base > rd.low)  ? rd.base - rd.low  : '0;
    above = (rd.high > rd.base) ? rd.high - rd.base : '0;
    if (rd.base == '0) begin
      span_num = '0;
      span_den = RD_W'(1);
    end else begin
      span_num = (below > above) ? below : above;
      span_den = rd.base;
    end
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_load = 1'b0;
    unique case (state_r)
      ST_THR: begin
        mul_a    = RD_W'(thr_r);
        mul_b    = rd.base;
        mul_load = 1'b1;
      end
      ST_SPAN: begin
        mul_a    = span_num;
        mul_b    = best_den_r;
        mul_load = 1'b1;
      end
      ST_CMP: begin
        mul_a = best_num_r;
        mul_b = span_den;
      end
      default: begin
      end
    endcase
  end

  tcd_mul_unit u_mul (
    .clk    (clk),
    .load   (mul_load),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod   (prod),
    .prod_r (prod_r)
  );

  // In the compare step prod_r holds num_i * best_den and prod holds
  // best_num * den_i.
  assign take = (rd.onset > best_hits_r) ||
                ((rd.onset == best_hits_r) && (rd.onset != '0) && (prod_r > prod));

  // Channel update; prod_r holds threshold * baseline here.
  always_comb begin
    diff        = (reading_r > rd.base) ? reading_r - rd.base : rd.base - reading_r;
    now_touched = (rd.base != '0) && (PROD_W'({diff, 10'd0}) > prod_r);
    sum_new     = rd.sum + SUM_W'(reading_r);
    seen_new    = rd.seen + SEEN_W'(1);
    base_new    = RD_W'(sum_new / CALIB_SAMPLES);
    rise        = 1'b0;
    done        = 1'b0;
    wr          = rd;
    if (func_r == FUNC_CALIB) begin
      wr.sum  = sum_new;
      wr.seen = seen_new;
      if (seen_new >= SEEN_W'(CALIB_SAMPLES)) begin
        done     = 1'b1;
        wr.base  = base_new;
        wr.low   = base_new;
        wr.high  = base_new;
        wr.flag  = 1'b0;
        wr.onset = '0;
        wr.sum   = '0;
        wr.seen  = '0;
      end
    end else begin
      if (reading_r < rd.low) begin
        wr.low = reading_r;
      end
      if (reading_r > rd.high) begin
        wr.high = reading_r;
      end
      if (now_touched && !rd.flag) begin
        rise = 1'b1;
        if (rd.onset < ONSET_MAX) begin
          wr.onset = rd.onset + RD_W'(1);
        end
      end
      wr.flag = now_touched;
    end
  end

  assign bank_we = (state_r == ST_UPD);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = bad_in ? ST_SPAN : ST_THR;
      ST_THR:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_SPAN;
      ST_SPAN: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = last_idx ? ST_IDLE : ST_SPAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_CMP) && last_idx;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_touch_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      ch_r         <= in_channel_index[CH_AW-1:0];
      reading_r    <= in_reading;
      idx_r        <= '0;
      have_r       <= 1'b0;
      best_r       <= '0;
      best_hits_r  <= '0;
      best_num_r   <= '0;
      best_den_r   <= RD_W'(1);
      bad_r        <= bad_in;
      is_touched_r <= 1'b0;
      rising_r     <= 1'b0;
      calib_done_r <= 1'b0;
      hit_total_r  <= '0;
      lowest_r     <= '0;
      highest_r    <= '0;
      baseline_r   <= '0;
    end
    if (state_r == ST_UPD) begin
      is_touched_r <= wr.flag;
      rising_r     <= rise;
      calib_done_r <= done;
      hit_total_r  <= wr.onset;
      lowest_r     <= wr.low;
      highest_r    <= wr.high;
      baseline_r   <= wr.base;
    end
    if (state_r == ST_CMP) begin
      if (take) begin
        have_r      <= 1'b1;
        best_r      <= idx_r;
        best_hits_r <= rd.onset;
        best_num_r  <= span_num;
        best_den_r  <= span_den;
      end
      if (last_idx) begin
        best_found_r   <= have_r || take;
        best_channel_r <= take ? 4'(idx_r) : (have_r ? 4'(best_r) : 4'd0);
      end else begin
        idx_r <= idx_r + CH_AW'(1);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_touched   = is_touched_r;
  assign out_rising_edge  = rising_r;
  assign out_hit_total    = hit_total_r;
  assign out_lowest_seen  = lowest_r;
  assign out_highest_seen = highest_r;
  assign out_baseline_out = baseline_r;
  assign out_calib_done   = calib_done_r;
  assign out_best_channel = best_channel_r;
  assign out_best_found   = best_found_r;
  assign out_bad_channel  = bad_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the sequencer is still running");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an input transfer");

  a_no_best_without_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_best_found) |-> (out_best_channel == 4'd0))
    else $error("best channel named although no channel has a hit");

  a_bad_channel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_channel) |->
      (!out_is_touched && !out_rising_edge && !out_calib_done))
    else $error("bad channel result carries channel flags");

  a_rise_means_touched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rising_edge) |-> (out_is_touched && !out_calib_done))
    else $error("touch onset reported without a touched channel");

endmodule
